@@ hdl/icf_pkg.sv @@
// icf_pkg: shared types and codes for the i2c chunk framer
// item structs, command record between front and back, status and register codes
// no dependencies

package icf_pkg;

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_FINAL_XOR = 8'd1;

    // input op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CFG_RESET = 32'hFFFFFFFF;

    typedef enum logic [1:0] {
        ST_WORD     = 2'd0,
        ST_BAD_LEN  = 2'd1,
        ST_NO_CHUNK = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_BAD_LEN,
        CMD_NO_CHUNK,
        CMD_HEADER,
        CMD_PAYLOAD
    } t_cmd_kind;

    typedef enum logic [1:0] {
        S_CMD,
        S_LEN_HI,
        S_LEN_LO
    } t_hdr_state;

    typedef struct packed {
        logic        op;
        logic [6:0]  target_addr;
        logic [7:0]  command;
        logic [15:0] chunk_length;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  word_byte;
        logic        stop_flag;
        logic [6:0]  dest_addr;
        logic        crc_valid;
        logic [31:0] crc_value;
        logic        run_end;
    } t_out_item;

    // classified work handed from front to back
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data;
        logic [15:0] length;
        logic [6:0]  addr;
        logic        last;
        logic [31:0] crc;
    } t_cmd;

endpackage

@@ hdl/icf_fifo.sv @@
// icf_fifo: small first-word-fall-through queue, head always in entry 0
// generic width and depth, no package use

module icf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    wr_pos;
    logic [AW-1:0]    wr_idx;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[0];

    // a pop shifts every entry one place toward the head
    assign wr_pos = i_rd ? (r_count - CW'(1)) : r_count;
    assign wr_idx = wr_pos[AW-1:0];

    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + CW'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // the entry taking the new word does not also shift
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
            if (i_rd && !(i_wr && (wr_idx == AW'(i)))) begin
                r_mem[i] <= r_mem[i+1];
            end
        end
        if (i_wr) begin
            r_mem[wr_idx] <= i_wdata;
        end
    end

endmodule

@@ hdl/icf_front.sv @@
// icf_front: accepts items, keeps chunk state and the running crc, issues commands
// uses icf_pkg types and codes

module icf_front #(
    parameter int MAX_CHUNK = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  icf_pkg::t_in_item              i_item,
    input  logic                           i_cmd_full,
    output logic                           o_cmd_wr,
    output icf_pkg::t_cmd                  o_cmd,
    input  logic                           i_cfg_wr,
    input  logic [icf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    localparam logic [15:0] MAX_LEN = 16'(MAX_CHUNK);

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (icf_pkg::CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    logic        r_open, n_open;
    logic [15:0] r_left, n_left;
    logic [31:0] r_crc, n_crc;
    logic [6:0]  r_addr, n_addr;
    logic [31:0] r_seed;
    logic [31:0] r_final_xor;

    logic        accept;
    logic        bad_len;
    logic [31:0] crc_next;
    logic [15:0] left_dec;

    assign accept   = i_push && !i_cmd_full;
    assign o_cmd_wr = accept;
    assign bad_len  = (i_item.chunk_length == 16'd0) || (i_item.chunk_length > MAX_LEN);
    assign crc_next = crc_byte(r_crc, i_item.data_byte);
    assign left_dec = r_left - 16'd1;

    always_comb begin
        n_open = r_open;
        n_left = r_left;
        n_crc  = r_crc;
        n_addr = r_addr;
        o_cmd  = '0;
        if (i_item.op == icf_pkg::OP_START) begin
            if (bad_len) begin
                o_cmd.kind = icf_pkg::CMD_BAD_LEN;
                n_open     = 1'b0;
                n_left     = 16'd0;
            end else begin
                o_cmd.kind   = icf_pkg::CMD_HEADER;
                o_cmd.data   = i_item.command;
                o_cmd.length = i_item.chunk_length;
                o_cmd.addr   = i_item.target_addr;
                n_open       = 1'b1;
                n_left       = i_item.chunk_length;
                n_crc        = r_seed;
                n_addr       = i_item.target_addr;
            end
        end else if (!r_open) begin
            o_cmd.kind = icf_pkg::CMD_NO_CHUNK;
        end else begin
            o_cmd.kind = icf_pkg::CMD_PAYLOAD;
            o_cmd.data = i_item.data_byte;
            o_cmd.addr = r_addr;
            o_cmd.last = (left_dec == 16'd0);
            o_cmd.crc  = (left_dec == 16'd0) ? (crc_next ^ r_final_xor) : 32'd0;
            n_crc      = crc_next;
            n_left     = left_dec;
            if (left_dec == 16'd0) begin
                n_open = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= 16'd0;
            r_crc  <= 32'd0;
            r_addr <= 7'd0;
        end else if (accept) begin
            r_open <= n_open;
            r_left <= n_left;
            r_crc  <= n_crc;
            r_addr <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= icf_pkg::CFG_RESET;
            r_final_xor <= icf_pkg::CFG_RESET;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                icf_pkg::CFG_CRC_SEED:      r_seed      <= i_cfg_data;
                icf_pkg::CFG_CRC_FINAL_XOR: r_final_xor <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/icf_back.sv @@
// icf_back: turns queued commands into result beats, three for a header
// uses icf_pkg types and codes

module icf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  icf_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_rd,
    input  logic               i_out_full,
    output logic               o_out_wr,
    output icf_pkg::t_out_item o_out
);

    icf_pkg::t_hdr_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= icf_pkg::S_CMD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd_rd = 1'b0;
        o_out_wr = 1'b0;
        o_out    = '0;
        if (!i_cmd_empty && !i_out_full) begin
            o_out_wr = 1'b1;
            unique case (i_cmd.kind)
                icf_pkg::CMD_BAD_LEN: begin
                    o_out.status  = icf_pkg::ST_BAD_LEN;
                    o_out.run_end = 1'b1;
                    o_cmd_rd      = 1'b1;
                end
                icf_pkg::CMD_NO_CHUNK: begin
                    o_out.status  = icf_pkg::ST_NO_CHUNK;
                    o_out.run_end = 1'b1;
                    o_cmd_rd      = 1'b1;
                end
                icf_pkg::CMD_PAYLOAD: begin
                    o_out.status    = icf_pkg::ST_WORD;
                    o_out.word_byte = i_cmd.data;
                    o_out.stop_flag = i_cmd.last;
                    o_out.dest_addr = i_cmd.addr;
                    o_out.crc_valid = i_cmd.last;
                    o_out.crc_value = i_cmd.crc;
                    o_out.run_end   = 1'b1;
                    o_cmd_rd        = 1'b1;
                end
                icf_pkg::CMD_HEADER: begin
                    o_out.status    = icf_pkg::ST_WORD;
                    o_out.dest_addr = i_cmd.addr;
                    unique case (r_state)
                        icf_pkg::S_CMD: begin
                            o_out.word_byte = i_cmd.data;
                            n_state         = icf_pkg::S_LEN_HI;
                        end
                        icf_pkg::S_LEN_HI: begin
                            o_out.word_byte = i_cmd.length[15:8];
                            n_state         = icf_pkg::S_LEN_LO;
                        end
                        icf_pkg::S_LEN_LO: begin
                            o_out.word_byte = i_cmd.length[7:0];
                            o_out.run_end   = 1'b1;
                            o_cmd_rd        = 1'b1;
                            n_state         = icf_pkg::S_CMD;
                        end
                        default: begin
                            n_state = icf_pkg::S_CMD;
                        end
                    endcase
                end
                default: begin
                    o_cmd_rd = 1'b1;
                end
            endcase
        end
    end

endmodule

@@ hdl/i2c_chunk_framer_crc32.sv @@
// i2c_chunk_framer_crc32: top level of the length-prefixed chunk framer with crc-32
// depends on icf_pkg, icf_fifo, icf_front and icf_back

// The framer takes one input beat per cycle (push while full is low) and
// gives result beats through a queue-style port (pop while empty is low).
// A start beat yields three header words (command, length high, length low),
// each payload beat one word; the last payload word carries the stop flag
// and the finished reflected crc-32 (poly 0xEDB88320, seed and final xor from
// configuration registers 0 and 1). Bad lengths and stray bytes each give one
// error result. Payload beats sustain one item per cycle while results are
// popped; a start beat holds the back-end header sequencer through its three
// header words, which the command queue (CMD_DEPTH entries) absorbs, so full
// rises after a run of starts or when results are left waiting in a full
// result queue. The first result of an item passes through the command queue
// and the result queue before it shows on the result ports. The configuration
// port is always ready; write it only while the block is idle.

module i2c_chunk_framer_crc32 #(
    parameter int MAX_CHUNK = 1024,
    parameter int CMD_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input beats
    input  logic                          push,
    output logic                          full,
    input  icf_pkg::t_in_item             i_in,
    // result beats
    output logic                          empty,
    input  logic                          pop,
    output icf_pkg::t_out_item            o_out,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [icf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    localparam int CMD_W = $bits(icf_pkg::t_cmd);
    localparam int OUT_W = $bits(icf_pkg::t_out_item);

    // front to command queue
    logic               cmd_wr;
    icf_pkg::t_cmd      cmd_wdata;
    logic               cmd_full;
    // command queue to back
    logic [CMD_W-1:0]   cmd_rdata;
    icf_pkg::t_cmd      cmd_head;
    logic               cmd_empty;
    logic               cmd_rd;
    // back to result queue
    logic               out_wr;
    icf_pkg::t_out_item out_wdata;
    logic               out_full;
    logic [OUT_W-1:0]   out_rdata;
    logic               pop_ok;

    assign o_cfg_ready = 1'b1;
    assign full        = cmd_full;
    assign pop_ok      = pop && !empty;

    // front: classify and keep chunk and crc state
    icf_front #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_in),
        .i_cmd_full  (cmd_full),
        .o_cmd_wr    (cmd_wr),
        .o_cmd       (cmd_wdata),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // decoupling queue between front and back
    icf_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_wdata (cmd_wdata),
        .o_full  (cmd_full),
        .i_rd    (cmd_rd),
        .o_rdata (cmd_rdata),
        .o_empty (cmd_empty)
    );

    assign cmd_head = icf_pkg::t_cmd'(cmd_rdata);

    // back: expand commands into result words
    icf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_rd    (cmd_rd),
        .i_out_full  (out_full),
        .o_out_wr    (out_wr),
        .o_out       (out_wdata)
    );

    // result queue, lets the back keep writing while a result waits
    icf_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (out_wr),
        .i_wdata (out_wdata),
        .o_full  (out_full),
        .i_rd    (pop_ok),
        .o_rdata (out_rdata),
        .o_empty (empty)
    );

    assign o_out = icf_pkg::t_out_item'(out_rdata);

    // no write into a full command queue
    a_cmd_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd_wr && cmd_full))
        else $error("command queue written while full");

    // back never writes a full result queue nor reads an empty command queue
    a_back_handshake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(out_wr && out_full) && !(cmd_rd && cmd_empty))
        else $error("back end handshake violated");

    // a finished crc only rides on the closing word of a chunk
    a_crc_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.crc_valid) |-> (o_out.stop_flag && o_out.run_end
            && o_out.status == icf_pkg::ST_WORD))
        else $error("crc reported on a word that does not close the chunk");

    // header sequencer leaves its first phase only while a header is at the head
    a_hdr_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (u_back.r_state != icf_pkg::S_CMD) |-> (!cmd_empty
            && cmd_head.kind == icf_pkg::CMD_HEADER))
        else $error("header sequencer running without a header command");

endmodule

@@ tb/testbench.sv @@
// testbench: self-checking bench for the i2c chunk framer with crc-32
// depends on icf_pkg and the i2c_chunk_framer_crc32 top level, and through it on icf_fifo, icf_front and icf_back

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import icf_pkg::*;

    localparam int MAX_CHUNK    = 1024;
    localparam int LIMIT_CYCLES = 200000;
    // receiver hold-off: after this many results it stops popping for a while
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 300;
    // indexes that name no register, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_NEXT_IDX = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_IDX = 8'hFF;

    // tracks the open chunk and running crc, and keeps the words still due
    class chunk_tracker;
        logic [31:0] seed;
        logic [31:0] final_xor;
        bit          open;
        logic [15:0] left;
        logic [31:0] crc;
        logic [6:0]  addr;
        t_out_item   words_due[$];
        int          errors;

        function new();
            seed      = CFG_RESET;
            final_xor = CFG_RESET;
            open      = 1'b0;
            left      = '0;
            crc       = '0;
            addr      = '0;
            errors    = 0;
        endfunction

        function void load_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == CFG_CRC_SEED) begin
                seed = data;
            end else if (idx == CFG_CRC_FINAL_XOR) begin
                final_xor = data;
            end
        endfunction

        // reflected crc-32, one byte, lsb first
        function logic [31:0] fold_byte(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c ^ {24'd0, b};
            for (int k = 0; k < 8; k++) begin
                r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
            end
            return r;
        endfunction

        // works out the words one accepted input beat causes
        function void frame_item(t_in_item it);
            t_out_item w;
            w = '0;
            if (it.op == OP_START) begin
                if (it.chunk_length == 16'd0 || it.chunk_length > MAX_CHUNK) begin
                    // rejected length also drops any open chunk
                    open      = 1'b0;
                    left      = '0;
                    w.status  = ST_BAD_LEN;
                    w.run_end = 1'b1;
                    words_due.push_back(w);
                end else begin
                    open        = 1'b1;
                    left        = it.chunk_length;
                    crc         = seed;
                    addr        = it.target_addr;
                    w.status    = ST_WORD;
                    w.dest_addr = addr;
                    w.word_byte = it.command;
                    words_due.push_back(w);
                    w.word_byte = it.chunk_length[15:8];
                    words_due.push_back(w);
                    w.word_byte = it.chunk_length[7:0];
                    w.run_end   = 1'b1;
                    words_due.push_back(w);
                end
            end else if (!open) begin
                w.status  = ST_NO_CHUNK;
                w.run_end = 1'b1;
                words_due.push_back(w);
            end else begin
                crc         = fold_byte(crc, it.data_byte);
                left        = left - 16'd1;
                w.status    = ST_WORD;
                w.word_byte = it.data_byte;
                w.dest_addr = addr;
                w.run_end   = 1'b1;
                if (left == 16'd0) begin
                    open        = 1'b0;
                    w.stop_flag = 1'b1;
                    w.crc_valid = 1'b1;
                    w.crc_value = crc ^ final_xor;
                end
                words_due.push_back(w);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0h actual %0h", name, want, seen);
                errors++;
            end
        endfunction

        function void check_word(t_out_item got);
            t_out_item want;
            if (words_due.size() == 0) begin
                $error("result beat with nothing expected: %0h", got);
                errors++;
                return;
            end
            want = words_due.pop_front();
            compare_field("status",    32'(want.status),    32'(got.status));
            compare_field("word_byte", 32'(want.word_byte), 32'(got.word_byte));
            compare_field("stop_flag", 32'(want.stop_flag), 32'(got.stop_flag));
            compare_field("dest_addr", 32'(want.dest_addr), 32'(got.dest_addr));
            compare_field("crc_valid", 32'(want.crc_valid), 32'(got.crc_valid));
            compare_field("crc_value", want.crc_value,      got.crc_value);
            compare_field("run_end",   32'(want.run_end),   32'(got.run_end));
        endfunction

        function int pending();
            return words_due.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    t_in_item             i_in;
    logic                 empty;
    logic                 pop;
    t_out_item            o_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    chunk_tracker frames;
    bit           tx_burst;
    int unsigned  cycle_count;

    i2c_chunk_framer_crc32 #(
        .MAX_CHUNK(MAX_CHUNK)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a hang or a missing result ends here
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // start beat; the data byte is don't-care, so randomize it
    function automatic t_in_item start_item(logic [6:0] addr, logic [7:0] cmd,
                                            logic [15:0] len);
        t_in_item it;
        it.op           = OP_START;
        it.target_addr  = addr;
        it.command      = cmd;
        it.chunk_length = len;
        it.data_byte    = 8'($urandom);
        return it;
    endfunction

    // payload beat; header fields are don't-care here
    function automatic t_in_item byte_item(logic [7:0] data);
        t_in_item it;
        it.op           = OP_BYTE;
        it.target_addr  = 7'($urandom);
        it.command      = 8'($urandom);
        it.chunk_length = 16'($urandom);
        it.data_byte    = data;
        return it;
    endfunction

    // offer one beat after a random gap; push stays high if the next gap is zero
    task automatic send_item(t_in_item it);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= it;
        // values read right after the edge are the ones the block sampled
        do @(posedge i_clk); while (full);
        frames.frame_item(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        frames.load_register(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering beats and let every expected word come out
    task automatic end_phase();
        push <= 1'b0;
        while (frames.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly well-formed chunks with random content, some noise and broken chunks
    task automatic run_random(int count);
        int          sent;
        int          pick;
        int          len;
        int          cut;
        logic [15:0] bad_len;
        sent = 0;
        while (sent < count) begin
            if (sent % 20 == 0) begin
                tx_burst = ($urandom_range(0, 2) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24)
                                                  : $urandom_range(1, 5);
                // sometimes the chunk is cut short and left open
                cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len - 1) : len;
                send_item(start_item(7'($urandom), 8'($urandom), 16'(len)));
                sent++;
                for (int k = 0; k < cut; k++) begin
                    send_item(byte_item(8'($urandom)));
                    sent++;
                end
                // stray byte right after a finished chunk
                if (cut == len && $urandom_range(0, 9) == 0) begin
                    send_item(byte_item(8'($urandom)));
                    sent++;
                end
            end else if (pick < 87) begin
                bad_len = ($urandom_range(0, 2) == 0) ? 16'd0
                        : 16'($urandom_range(MAX_CHUNK + 1, 65535));
                send_item(start_item(7'($urandom), 8'($urandom), bad_len));
                sent++;
            end else begin
                send_item(byte_item(8'($urandom)));
                sent++;
            end
        end
    endtask

    // result side: random pops, one long hold-off so the block fills and stalls
    initial begin : result_side
        int gap;
        int taken;
        bit rx_burst;
        bit held;
        taken    = 0;
        rx_burst = 1'b0;
        held     = 1'b0;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken == HOLD_AT && !held) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, 16);
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            frames.check_word(o_out);
            taken++;
            if (taken % 16 == 0) begin
                rx_burst = ($urandom_range(0, 2) == 0);
            end
        end
    end

    initial begin
        frames   = new();
        tx_burst = 1'b0;
        push        <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, registers still at their reset values
        send_item(start_item(7'h00, 8'h00, 16'd1));
        send_item(byte_item(8'h00));              // single byte chunk, crc on it
        send_item(start_item(7'h7F, 8'hFF, 16'd2));
        send_item(byte_item(8'hFF));
        send_item(byte_item(8'hA5));              // closes the chunk
        send_item(byte_item(8'h3C));              // byte with no chunk open
        send_item(start_item(7'h11, 8'h22, 16'd0));             // zero length
        send_item(start_item(7'h33, 8'h44, 16'(MAX_CHUNK + 1))); // just too long
        send_item(start_item(7'h55, 8'h66, 16'hFFFF));          // longest field value
        send_item(start_item(7'h55, 8'h12, 16'(MAX_CHUNK)));    // largest legal length
        send_item(byte_item(8'h01));
        // start while open abandons the old chunk
        send_item(start_item(7'h2A, 8'h80, 16'd3));
        send_item(byte_item(8'h31));
        send_item(byte_item(8'h32));
        // bad length drops the open chunk, next byte is stray
        send_item(start_item(7'h2B, 8'h81, 16'd0));
        send_item(byte_item(8'h33));
        send_item(start_item(7'h01, 8'h7E, 16'h0100));
        send_item(start_item(7'h7F, 8'hC3, 16'd1));
        send_item(byte_item(8'h80));
        end_phase();

        // zero seed, zero final xor
        write_reg(CFG_CRC_SEED, 32'h0000_0000);
        write_reg(CFG_CRC_FINAL_XOR, 32'h0000_0000);
        run_random(30);
        end_phase();

        // all-ones seed, zero xor; writes to unused indexes change nothing
        write_reg(CFG_CRC_SEED, 32'hFFFF_FFFF);
        write_reg(CFG_NEXT_IDX, $urandom);
        write_reg(CFG_LAST_IDX, $urandom);
        run_random(30);
        end_phase();

        // random register values
        write_reg(CFG_CRC_SEED, $urandom);
        write_reg(CFG_CRC_FINAL_XOR, $urandom);
        run_random(30);
        end_phase();

        repeat (8) @(posedge i_clk);
        if (frames.errors == 0 && frames.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
